[sv/polygon_grid_cell_coverage_unit_defines.svh]
// Assertion macros shared by the polygon grid cell coverage unit.
`ifndef POLYGON_GRID_CELL_COVERAGE_UNIT_DEFINES_SVH
`define POLYGON_GRID_CELL_COVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PGCC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PGCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pgcc_pkg.sv]
// Shared types and constants of the polygon grid cell coverage unit.
package pgcc_pkg;

    localparam int SLOT_BITS  = 6;
    localparam int TOTAL_BITS = 7;
    localparam int CELL_SIZE_RESET = 256;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    typedef enum logic [1:0] {
        REG_VERTEX_TOTAL = 2'd0,
        REG_CELL_SIZE    = 2'd1,
        REG_ORIGIN_X     = 2'd2,
        REG_ORIGIN_Z     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic store_vertex;
        logic capture;
        logic scale_x;
        logic scale_z;
        logic finish_z;
        logic take_prev;
        logic edge_mul;
        logic edge_cmp;
        logic out_load;
    } pgcc_cmd_t;

    typedef struct packed {
        logic few_vertices;
        logic out_busy;
    } pgcc_stat_t;

endpackage

[sv/pgcc_ctrl.sv]
// Controller state machine: sequences cell setup and the edge walk.
`include "polygon_grid_cell_coverage_unit_defines.svh"
module pgcc_ctrl #(
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    input  logic [CW-1:0]       vert_num,
    input  pgcc_pkg::pgcc_stat_t stat,
    output pgcc_pkg::pgcc_cmd_t  cmd,
    output logic [AW-1:0]       rd_addr
);
    import pgcc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCALE_X, ST_SCALE_Z, ST_FINISH_Z, ST_PREP,
        ST_LOAD_PREV, ST_MUL, ST_CMP, ST_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          last_edge;

    assign last_edge = (CW'(idx_reg) + CW'(1)) == vert_num;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == ACT_TEST) state_next = ST_SCALE_X;
            end
            ST_SCALE_X:  state_next = ST_SCALE_Z;
            ST_SCALE_Z:  state_next = ST_FINISH_Z;
            ST_FINISH_Z: state_next = stat.few_vertices ? ST_DONE : ST_PREP;
            ST_PREP:     state_next = ST_LOAD_PREV;
            ST_LOAD_PREV: begin
                idx_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: state_next = ST_CMP;
            ST_CMP: begin
                if (last_edge) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        case (state_reg)
            ST_PREP:      rd_addr = AW'(vert_num - CW'(1));
            ST_CMP:       rd_addr = idx_reg + AW'(1);
            default:      rd_addr = '0;
        endcase
    end

    assign s_tready         = (state_reg == ST_IDLE);
    assign cmd.store_vertex = s_tready && s_tvalid && s_tuser == ACT_LOAD;
    assign cmd.capture      = s_tready && s_tvalid && s_tuser == ACT_TEST;
    assign cmd.scale_x      = (state_reg == ST_SCALE_X);
    assign cmd.scale_z      = (state_reg == ST_SCALE_Z);
    assign cmd.finish_z     = (state_reg == ST_FINISH_Z);
    assign cmd.take_prev    = (state_reg == ST_LOAD_PREV);
    assign cmd.edge_mul     = (state_reg == ST_MUL);
    assign cmd.edge_cmp     = (state_reg == ST_CMP);
    assign cmd.out_load     = (state_reg == ST_DONE) && !stat.out_busy;

    `PGCC_ASSERT_IMPL(a_idx_range, state_reg == ST_MUL, CW'(idx_reg) < vert_num, "idx overrun")
    `PGCC_ASSERT_NEXT(a_start_scale, cmd.capture, state_reg == ST_SCALE_X, "setup not started")
    `PGCC_ASSERT_IMPL(a_walk_enough, state_reg == ST_PREP, !stat.few_vertices, "walk below three")

endmodule

[sv/pgcc_dpath.sv]
// Datapath: configuration, vertex store, centre/corner math and edge crossing test.
module pgcc_dpath #(
    parameter int MAX_VERTICES    = 64,
    parameter int COORD_BITS      = 24,
    parameter int CELL_INDEX_BITS = 12,
    parameter int AW              = 6,
    parameter int CW              = 7,
    parameter int S_DATA_W        = 80,
    parameter int M_DATA_W        = 80
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_wdata,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  pgcc_pkg::pgcc_cmd_t   cmd,
    input  logic [AW-1:0]         rd_addr,
    output pgcc_pkg::pgcc_stat_t  stat,
    output logic [CW-1:0]         vert_num,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata
);
    import pgcc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int IW = CELL_INDEX_BITS;
    localparam int PW = IW + C - 1;
    localparam int W  = IW + C + 2;
    localparam int EW = C + 3;
    localparam int XW = 2 * EW;
    localparam int OFS_X   = SLOT_BITS;
    localparam int OFS_Z   = SLOT_BITS + C;
    localparam int OFS_COL = SLOT_BITS + 2 * C;
    localparam int OFS_ROW = SLOT_BITS + 2 * C + IW;
    localparam int M_USED  = 1 + 2 * C + 2 * IW;

    // configuration registers
    logic [TOTAL_BITS-1:0] total_reg;
    logic [C-2:0]          size_reg;
    logic [C-1:0]          org_x_reg, org_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            size_reg  <= (C-1)'(CELL_SIZE_RESET);
            org_x_reg <= '0;
            org_z_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_VERTEX_TOTAL: total_reg <= cfg_wdata[TOTAL_BITS-1:0];
                REG_CELL_SIZE:    size_reg  <= cfg_wdata[C-2:0];
                REG_ORIGIN_X:     org_x_reg <= cfg_wdata;
                REG_ORIGIN_Z:     org_z_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign vert_num = (32'(total_reg) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(total_reg);
    assign stat.few_vertices = (32'(vert_num) < 3);

    // input fields
    logic [SLOT_BITS-1:0] in_slot;
    logic [C-1:0]         in_x, in_z;
    logic [IW-1:0]        in_col, in_row;
    assign in_slot = s_tdata[SLOT_BITS-1:0];
    assign in_x    = s_tdata[OFS_X +: C];
    assign in_z    = s_tdata[OFS_Z +: C];
    assign in_col  = s_tdata[OFS_COL +: IW];
    assign in_row  = s_tdata[OFS_ROW +: IW];

    // vertex store
    logic [C-1:0] mem_x [MAX_VERTICES];
    logic [C-1:0] mem_z [MAX_VERTICES];
    logic [C-1:0] rd_x_reg, rd_z_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store_vertex && 32'(in_slot) < MAX_VERTICES) begin
            mem_x[AW'(in_slot)] <= in_x;
            mem_z[AW'(in_slot)] <= in_z;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_z_reg <= mem_z[rd_addr];
    end

    // cell setup: index * cell_size, then corner and doubled centre
    logic [IW-1:0] col_reg, row_reg;
    logic [PW-1:0] prod_reg;
    logic [C-1:0]  corner_x_reg, corner_z_reg;
    logic signed [C+1:0] px_reg, pz_reg;

    logic signed [W-1:0] o_w, p_w, cs_w, corner_sum, centre_sum;
    logic signed [W-1:0] coord_max_w, dbl_limit_w;
    logic [C-1:0]        corner_val;
    logic signed [C+1:0] centre_val;

    always_comb begin
        o_w         = cmd.scale_z ? W'($signed(org_x_reg)) : W'($signed(org_z_reg));
        p_w         = $signed({3'b000, prod_reg});
        cs_w        = $signed({{(W-C+1){1'b0}}, size_reg});
        coord_max_w = $signed({{(W-C+1){1'b0}}, {(C-1){1'b1}}});
        dbl_limit_w = $signed({{(W-C-1){1'b0}}, 1'b1, {C{1'b0}}});
        corner_sum  = o_w + p_w;
        centre_sum  = (o_w <<< 1) + (p_w <<< 1) + cs_w;
        corner_val  = (corner_sum > coord_max_w) ? coord_max_w[C-1:0] : corner_sum[C-1:0];
        centre_val  = (centre_sum > dbl_limit_w) ? dbl_limit_w[C+1:0] : centre_sum[C+1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            col_reg <= in_col;
            row_reg <= in_row;
        end
        if (cmd.scale_x || cmd.scale_z) begin
            prod_reg <= PW'((cmd.scale_x ? col_reg : row_reg) * size_reg);
        end
        if (cmd.scale_z) begin
            corner_x_reg <= corner_val;
            px_reg       <= centre_val;
        end
        if (cmd.finish_z) begin
            corner_z_reg <= corner_val;
            pz_reg       <= centre_val;
        end
    end

    // edge crossing: vertex i from the store, vertex i-1 held in prev
    logic [C-1:0] prev_x_reg, prev_z_reg;
    logic signed [EW-1:0] ax, az, bx, bz, pxe, pze, dxp, dd, ex, dz;
    logic signed [XW-1:0] lhs_reg, rhs_reg;
    logic                 cond_reg, dpos_reg, inside_reg, crossing;

    always_comb begin
        ax  = $signed({{2{rd_x_reg[C-1]}}, rd_x_reg, 1'b0});
        az  = $signed({{2{rd_z_reg[C-1]}}, rd_z_reg, 1'b0});
        bx  = $signed({{2{prev_x_reg[C-1]}}, prev_x_reg, 1'b0});
        bz  = $signed({{2{prev_z_reg[C-1]}}, prev_z_reg, 1'b0});
        pxe = $signed({px_reg[C+1], px_reg});
        pze = $signed({pz_reg[C+1], pz_reg});
        dxp = pxe - ax;
        dd  = bz - az;
        ex  = bx - ax;
        dz  = pze - az;
        crossing = dpos_reg ? (lhs_reg < rhs_reg) : (rhs_reg < lhs_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_prev || cmd.edge_mul) begin
            prev_x_reg <= rd_x_reg;
            prev_z_reg <= rd_z_reg;
        end
        if (cmd.edge_mul) begin
            lhs_reg  <= XW'(dxp) * XW'(dd);
            rhs_reg  <= XW'(ex) * XW'(dz);
            cond_reg <= (az > pze) != (bz > pze);
            dpos_reg <= (dd > 0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
        end else if (cmd.capture) begin
            inside_reg <= 1'b0;
        end else if (cmd.edge_cmp && cond_reg && crossing) begin
            inside_reg <= !inside_reg;
        end
    end

    // output register
    logic                m_valid_reg;
    logic [M_USED-1:0]   m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {row_reg, col_reg, corner_z_reg, corner_x_reg, inside_reg};
        end
    end

    assign stat.out_busy = m_valid_reg && !m_tready;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = {{(M_DATA_W-M_USED){1'b0}}, m_data_reg};

endmodule

[sv/polygon_grid_cell_coverage_unit.sv]
// Top level of the polygon grid cell coverage unit.
//
//   Channel   Direction  Contents (lowest bits first)
//   s_*       in         tuser: action; tdata: slot, vertex x, vertex z, col, row
//   m_*       out        tdata: covered, corner x, corner z, col echo, row echo
//   cfg_*     in         write-only registers: total, cell size, origin x, origin z
//
// A vertex load transaction returns nothing.
// A cell test: setup (scale x, scale z, finish z, prep, load prev), then cross products and
// compare for each stored edge, then a handoff; the next test is taken after the handoff.
// With fewer than three vertices the walk is skipped.
// Reset sets control state, output valid and config registers (cell size to 256); the vertex store has no reset.
// A new transaction is taken while a result waits; the handoff stalls only when a second result is ready.
module polygon_grid_cell_coverage_unit #(
    parameter int MAX_VERTICES    = 64,
    parameter int COORD_BITS      = 24,
    parameter int CELL_INDEX_BITS = 12,
    parameter int S_DATA_W = ((6 + 2 * COORD_BITS + 2 * CELL_INDEX_BITS + 7) / 8) * 8,
    parameter int M_DATA_W = ((1 + 2 * COORD_BITS + 2 * CELL_INDEX_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_wdata,
    // input transactions
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // vertex_slot, vertex_x, vertex_z, cell_col, cell_row
    input  logic                  s_tuser,   // action
    // result transactions
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // covered, corner_x, corner_z, col_echo, row_echo
);
    import pgcc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    pgcc_cmd_t     cmd;
    pgcc_stat_t    stat;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] vert_num;

    // sequence setup, edge walk and output handoff
    pgcc_ctrl #(
        .AW(AW),
        .CW(CW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tuser      (s_tuser),
        .s_tready     (s_tready),
        .vert_num     (vert_num),
        .stat         (stat),
        .cmd          (cmd),
        .rd_addr      (rd_addr)
    );

    // hold registers and the vertex store, do the arithmetic
    pgcc_dpath #(
        .MAX_VERTICES    (MAX_VERTICES),
        .COORD_BITS      (COORD_BITS),
        .CELL_INDEX_BITS (CELL_INDEX_BITS),
        .AW              (AW),
        .CW              (CW),
        .S_DATA_W        (S_DATA_W),
        .M_DATA_W        (M_DATA_W)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_tdata      (s_tdata),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .stat         (stat),
        .vert_num     (vert_num),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
